// ----- rtl/core/gaussian_kernel_eval_macros.svh -----
// ----------------------------------------------------------------------------
// gaussian_kernel_eval_macros.svh
// assertion macros used by the checker file of the kernel evaluator
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_KERNEL_EVAL_MACROS_SVH
`define GAUSSIAN_KERNEL_EVAL_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GKE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gke assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define GKE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gke assertion failed");

`endif

// ----- rtl/core/gke_pkg.sv -----
// ----------------------------------------------------------------------------
// gke_pkg
// types, constants and the exponent table of the gaussian kernel evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package gke_pkg;

	localparam int ACC_W          = 48;
	localparam int HALF_W         = ACC_W / 2;
	localparam int EXP_TABLE_SIZE = 256;
	localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);
	localparam int SERIES_TERMS   = 24;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [30:0] LOG2E_Q30       = 31'd1549082005;
	localparam logic [31:0] LN2_Q32         = 32'd2977044472;
	localparam logic [31:0] INV_SIGMA_RESET = 32'd65536;

	typedef struct packed {
		logic [ACC_W-1:0] dist2;
		logic             sat;
	} dist_entry_t;

	typedef logic [EXP_TABLE_SIZE-1:0][15:0] exp_tab_t;

	// 2^-(i/size) in q1.15 from a truncated taylor series of exp(-i*ln2/size)
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    tab;
		logic [63:0] z;
		logic [63:0] term;
		logic [63:0] sum;
		for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
			z    = (64'(i) * 64'(LN2_Q32)) / 64'(EXP_TABLE_SIZE);
			term = 64'd1 << 32;
			sum  = term;
			for (int k = 1; k <= SERIES_TERMS; k++) begin
				term = ((term * z) >> 32) / 64'(k);
				if (k[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			tab[i] = 16'((sum + (64'd1 << 16)) >> 17);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ----- rtl/core/gke_if.sv -----
// ----------------------------------------------------------------------------
// gke_if
// valid/ready channels of the kernel evaluator: pairs, results, configuration
// ----------------------------------------------------------------------------
`default_nettype none

interface gke_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] elem_a;
	logic signed [15:0] elem_b;
	logic               last;

	modport source (output valid, output elem_a, output elem_b, output last, input ready);
	modport sink (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface gke_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] kernel_value;
	logic        acc_saturated;

	modport source (output valid, output kernel_value, output acc_saturated, input ready);
	modport sink (input valid, input kernel_value, input acc_saturated, output ready);
endinterface

interface gke_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gke_front.sv -----
// ----------------------------------------------------------------------------
// gke_front
// squared-difference pipeline and saturating distance accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module gke_front (
	input  logic                clk,
	input  logic                arst_n,
	gke_in_if.sink              elems,
	output logic                push_valid,
	input  logic                push_ready,
	output gke_pkg::dist_entry_t push_data
);
	import gke_pkg::*;

	logic               valid_s1;
	logic               valid_s2;
	logic [15:0]        absd_s1;
	logic               last_s1;
	logic [31:0]        sq_s2;
	logic               last_s2;
	logic [ACC_W-1:0]   acc_q;
	logic               sat_q;
	logic signed [16:0] diff;
	logic [15:0]        absd;
	logic [ACC_W:0]     sum;
	logic               ovf;
	logic [ACC_W-1:0]   acc_next;
	logic               stall;

	assign diff = {elems.elem_a[15], elems.elem_a} - {elems.elem_b[15], elems.elem_b};
	assign absd = diff[16] ? 16'(~diff + 17'sd1) : diff[15:0];

	assign sum      = {1'b0, acc_q} + (ACC_W + 1)'(sq_s2);
	assign ovf      = sum[ACC_W];
	assign acc_next = ovf ? '1 : sum[ACC_W-1:0];

	assign push_valid      = valid_s2 && last_s2;
	assign push_data.dist2 = acc_next;
	assign push_data.sat   = sat_q | ovf;

	assign stall       = push_valid && !push_ready;
	assign elems.ready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
			sat_q    <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= elems.valid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (last_s2) begin
					acc_q <= '0;
					sat_q <= 1'b0;
				end else begin
					acc_q <= acc_next;
					sat_q <= sat_q | ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			absd_s1 <= absd;
			last_s1 <= elems.last;
			sq_s2   <= 32'(absd_s1) * 32'(absd_s1);
			last_s2 <= last_s1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/gke_queue.sv -----
// ----------------------------------------------------------------------------
// gke_queue
// short fifo of finished distances between accumulator and exponent unit
// ----------------------------------------------------------------------------
`default_nettype none

module gke_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  gke_pkg::dist_entry_t push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output gke_pkg::dist_entry_t pop_data
);
	import gke_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	dist_entry_t      slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/gke_back.sv -----
// ----------------------------------------------------------------------------
// gke_back
// exponent sequencer: scale by inv_sigma, convert to base 2, table and shift
// ----------------------------------------------------------------------------
`default_nettype none

module gke_back (
	input  logic                 clk,
	input  logic                 arst_n,
	gke_cfg_if.sink              cfg,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  gke_pkg::dist_entry_t pop_data,
	gke_out_if.source            result
);
	import gke_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HI   = 3'd1;
	localparam logic [2:0] ST_LO   = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_LOG  = 3'd4;
	localparam logic [2:0] ST_TAB  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]           state_q;
	logic [31:0]          inv_q;
	logic [ACC_W-1:0]     dist_q;
	logic                 sat_q;
	logic [55:0]          phi_q;
	logic [55:0]          plo_q;
	logic [19:0]          x_q;
	logic [50:0]          ylog_q;
	logic                 zero_q;
	logic [15:0]          entry_q;
	logic [3:0]           n_q;
	logic                 out_valid_q;
	logic [15:0]          kernel_q;
	logic                 sat_out_q;
	logic [56:0]          p_sum;
	logic [20:0]          y_val;
	logic [28:0]          idx_prod;
	logic [EXP_IDX_W-1:0] idx;
	logic [16:0]          rounded;
	logic [15:0]          kernel_val;
	logic                 out_free;

	assign p_sum    = {21'b0, phi_q[11:0], 24'b0} + {1'b0, plo_q};
	assign y_val    = ylog_q[50:30];
	assign idx_prod = 29'(y_val[15:0]) * 29'(EXP_TABLE_SIZE);
	assign idx      = idx_prod[16 +: EXP_IDX_W];
	assign rounded  = 17'(entry_q) + ((17'd1 << n_q) >> 1);
	assign kernel_val = zero_q ? '0 : 16'(rounded >> n_q);
	assign out_free = !out_valid_q || result.ready;

	assign pop_ready            = state_q == ST_IDLE;
	assign cfg.ready            = 1'b1;
	assign result.valid         = out_valid_q;
	assign result.kernel_value  = kernel_q;
	assign result.acc_saturated = sat_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inv_q       <= INV_SIGMA_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				inv_q <= cfg.data;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (pop_valid) state_q <= ST_HI;
				ST_HI:   state_q <= ST_LO;
				ST_LO:   state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_LOG;
				ST_LOG:  state_q <= ST_TAB;
				ST_TAB:  state_q <= ST_FIN;
				ST_FIN:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					dist_q <= pop_data.dist2;
					sat_q  <= pop_data.sat;
				end
			end
			ST_HI: begin
				phi_q <= 56'(dist_q[ACC_W-1:HALF_W]) * 56'(inv_q);
			end
			ST_LO: begin
				plo_q  <= 56'(dist_q[HALF_W-1:0]) * 56'(inv_q);
				zero_q <= |phi_q[55:12];
			end
			ST_SUM: begin
				zero_q <= zero_q | (|p_sum[56:36]);
				x_q    <= p_sum[35:16];
			end
			ST_LOG: begin
				ylog_q <= 51'(x_q) * 51'(LOG2E_Q30) + (51'd1 << 29);
			end
			ST_TAB: begin
				zero_q  <= zero_q | y_val[20];
				n_q     <= y_val[19:16];
				entry_q <= EXP_TAB[idx];
			end
			ST_FIN: begin
				if (out_free) begin
					kernel_q  <= kernel_val;
					sat_out_q <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/gaussian_kernel_eval.sv -----
// ----------------------------------------------------------------------------
// gaussian_kernel_eval
// streaming gaussian rbf kernel: exp(-|a-b|^2 * inv_sigma) in q1.15
// ----------------------------------------------------------------------------
// elems carries one q8.8 pair per transaction, last marks the final pair of
// the two vectors. result carries one transaction per vector pair: the kernel
// value and a flag telling that the 48-bit distance sum saturated. cfg writes
// inv_sigma (q16.16) and is always ready; write it only while the block idles.
// pairs are taken at one per cycle while elems.ready is high. the sequencer
// steps through idle, hi, lo, sum, log, tab and fin for each vector, taking a
// new sum only when idle. a two-entry queue holds finished sums, so vectors
// with fewer pairs than sequencer states slow the input once the queue fills.
// if result is stalled the result holds, the sequencer waits at its final
// step, then the queue fills and elems.ready drops on the next last pair.
// reset clears the sum, the flag, the queue and any pending result, and sets
// inv_sigma to 1.0. there is no clearing pass: pairs are taken right away.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_kernel_eval (
	input  logic      clk,
	input  logic      arst_n,
	gke_in_if.sink    elems,
	gke_cfg_if.sink   cfg,
	gke_out_if.source result
);
	import gke_pkg::*;

	logic        push_valid;
	logic        push_ready;
	dist_entry_t push_data;
	logic        pop_valid;
	logic        pop_ready;
	dist_entry_t pop_data;

	gke_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.elems      (elems),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	gke_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	gke_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

`default_nettype wire

// ----- rtl/core/gke_checker.sv -----
// ----------------------------------------------------------------------------
// gke_checker
// port-level checks on the result channel of the kernel evaluator
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_kernel_eval_macros.svh"

module gke_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] kernel_value,
	input logic        acc_saturated
);

	`GKE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`GKE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(kernel_value) && $stable(acc_saturated))
	`GKE_ASSERT_NOW(a_sat_value, out_valid && acc_saturated, kernel_value == 16'd0 || kernel_value == 16'd32768)
	`GKE_ASSERT_NOW(a_reset_quiet, $rose(arst_n), !out_valid)

endmodule

bind gaussian_kernel_eval gke_checker u_gke_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.kernel_value  (result.kernel_value),
	.acc_saturated (result.acc_saturated)
);

`default_nettype wire
